// ===== src/aet_pkg.sv =====
package aet_pkg;

    localparam int NUM_PARAMS = 5;
    localparam int TAB_WIDTH  = 8;
    localparam int PARAM_W    = 16;
    localparam int SLOT_W     = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
    localparam int CNT_W      = $clog2(NUM_PARAMS + 1);
    localparam logic [PARAM_W-1:0] PARAM_MAX = '1;

    // parser modes
    localparam logic [2:0] PM_GROUND = 3'd0;
    localparam logic [2:0] PM_ESC    = 3'd1;
    localparam logic [2:0] PM_CSI    = 3'd2;
    localparam logic [2:0] PM_PRIV   = 3'd3;
    localparam logic [2:0] PM_SCS0   = 3'd4;
    localparam logic [2:0] PM_SCS1   = 3'd5;

    // result commands
    localparam logic [1:0] CMD_DRAW   = 2'd0;
    localparam logic [1:0] CMD_ERASE  = 2'd1;
    localparam logic [1:0] CMD_SCROLL = 2'd2;

    // config registers
    localparam int         CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;
    localparam logic [7:0] COLS_RESET = 8'd80;
    localparam logic [7:0] ROWS_RESET = 8'd25;

    // bytes of interest
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SO    = 8'h0E;
    localparam logic [7:0] CH_SI    = 8'h0F;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] FIN_UP   = 8'h41;
    localparam logic [7:0] FIN_DOWN = 8'h42;
    localparam logic [7:0] FIN_FWD  = 8'h43;
    localparam logic [7:0] FIN_BACK = 8'h44;
    localparam logic [7:0] FIN_POS  = 8'h48;
    localparam logic [7:0] FIN_ED   = 8'h4A;
    localparam logic [7:0] FIN_EL   = 8'h4B;
    localparam logic [7:0] FIN_SGR  = 8'h6D;

    localparam logic [2:0] FG_RESET = 3'd7;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] glyph;
        logic [7:0] left_col;
        logic [7:0] top_row;
        logic [7:0] right_col;
        logic [7:0] bottom_row;
        logic [7:0] scroll_lines;
        logic [3:0] fg_index;
        logic [2:0] bg_index;
        logic       bold;
        logic       last;
    } res_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic sgr_step;
        logic sel_second;
    } ctl_cmd_t;

    typedef struct packed {
        logic has_res;
        logic sgr_start;
        logic sgr_last;
        logic two_res;
    } ctl_stat_t;

endpackage

// ===== src/aet_if.sv =====
interface aet_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface aet_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] glyph;
    logic [7:0] left_col;
    logic [7:0] top_row;
    logic [7:0] right_col;
    logic [7:0] bottom_row;
    logic [7:0] scroll_lines;
    logic [3:0] fg_index;
    logic [2:0] bg_index;
    logic       bold;
    logic       last;
    modport source (output valid, output cmd, output glyph, output left_col,
                    output top_row, output right_col, output bottom_row,
                    output scroll_lines, output fg_index, output bg_index,
                    output bold, output last, input ready);
    modport sink   (input valid, input cmd, input glyph, input left_col,
                    input top_row, input right_col, input bottom_row,
                    input scroll_lines, input fg_index, input bg_index,
                    input bold, input last, output ready);
endinterface

// ===== src/aet_ctrl.sv =====
module aet_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  aet_pkg::ctl_stat_t  stat,
    output aet_pkg::ctl_cmd_t   cmd
);
    import aet_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SGR  = 3'd2;
    localparam logic [2:0] S_OUT0 = 3'd3;
    localparam logic [2:0] S_OUT1 = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.sgr_start)
                    state_next = S_SGR;
                else if (stat.has_res)
                    state_next = S_OUT0;
                else
                    state_next = S_IDLE;
            end
            S_SGR:
            begin
                cmd.sgr_step = 1'b1;
                if (stat.sgr_last)
                    state_next = S_IDLE;
            end
            S_OUT0:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = stat.two_res ? S_OUT1 : S_IDLE;
            end
            S_OUT1:
            begin
                out_valid      = 1'b1;
                cmd.sel_second = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== src/aet_dp.sv =====
module aet_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [7:0]                    ch,
    input  logic                          cfg_we,
    input  logic [aet_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [7:0]                    cfg_data,
    input  aet_pkg::ctl_cmd_t             cmd,
    output aet_pkg::ctl_stat_t            stat,
    output aet_pkg::res_t                 res
);
    import aet_pkg::*;

    typedef struct packed {
        logic       scroll;
        logic [7:0] lines;
        logic [7:0] row;
    } down_t;

    function automatic down_t calc_down(input logic [7:0] row, input logic [16:0] add,
                                        input logic [7:0] rows);
        logic [17:0] ny;
        logic [17:0] s;
        down_t       d;
        ny = {10'd0, row} + {1'b0, add};
        s  = '0;
        d  = '0;
        if (ny >= {10'd0, rows})
        begin
            s = ny - {10'd0, rows} + 18'd1;
            if (s > {10'd0, rows})
                s = {10'd0, rows};
            d.scroll = 1'b1;
            d.lines  = s[7:0];
            d.row    = rows - 8'd1;
        end
        else
            d.row = ny[7:0];
        return d;
    endfunction

    function automatic res_t mk(input logic [1:0] c, input logic [7:0] g,
                                input logic [7:0] l, input logic [7:0] t,
                                input logic [7:0] r, input logic [7:0] b,
                                input logic [7:0] s);
        res_t x;
        x              = '0;
        x.cmd          = c;
        x.glyph        = g;
        x.left_col     = l;
        x.top_row      = t;
        x.right_col    = r;
        x.bottom_row   = b;
        x.scroll_lines = s;
        return x;
    endfunction

    logic [7:0]         ch_reg;
    logic [7:0]         cols_reg, cols_next, rows_reg, rows_next;
    logic [2:0]         mode_reg, mode_next;
    logic [PARAM_W-1:0] params_reg [NUM_PARAMS];
    logic [PARAM_W-1:0] params_next [NUM_PARAMS];
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               digit_reg, digit_next;
    logic [SLOT_W-1:0]  sgr_idx_reg, sgr_idx_next;
    logic [7:0]         col_reg, col_next, row_reg, row_next;
    logic [7:0]         g0_reg, g0_next, g1_reg, g1_next;
    logic               so_reg, so_next;
    logic [2:0]         fg_reg, fg_next, bg_reg, bg_next;
    logic               bold_reg, bold_next;
    res_t               res0_reg, res1_reg, e0, e1, r0, r1;
    logic               two_reg;
    logic [1:0]         n;

    logic [7:0]         cols, rows, set, gch, eff;
    logic [SLOT_W-1:0]  rd_idx;
    logic [PARAM_W-1:0] rd_val, p0, amt, pc, v;
    logic [CNT_W-1:0]   cnt;
    logic [19:0]        acc;
    logic [16:0]        nx;
    logic [8:0]         tab;
    logic [15:0]        hr, hc;
    logic [8:0]         e;
    down_t              dn;

    assign cols   = (cols_reg == 8'd0) ? 8'd1 : cols_reg;
    assign rows   = (rows_reg == 8'd0) ? 8'd1 : rows_reg;
    assign cnt    = CNT_W'(slot_reg) + CNT_W'(digit_reg);
    assign rd_idx = cmd.sgr_step ? sgr_idx_reg : slot_reg;
    assign rd_val = params_reg[rd_idx];
    assign p0     = (cnt != '0) ? params_reg[0] : '0;
    assign amt    = (p0 != '0) ? p0 : PARAM_W'(1);

    assign stat.has_res   = (n != 2'd0);
    assign stat.sgr_start = (mode_reg == PM_CSI) && (ch_reg == FIN_SGR);
    assign stat.sgr_last  = (cnt == '0) || (CNT_W'(sgr_idx_reg) == cnt - CNT_W'(1));
    assign stat.two_res   = two_reg;

    assign res = cmd.sel_second ? res1_reg : res0_reg;

    always_comb
    begin
        cols_next   = cols_reg;
        rows_next   = rows_reg;
        mode_next   = mode_reg;
        params_next = params_reg;
        slot_next   = slot_reg;
        digit_next  = digit_reg;
        sgr_idx_next = sgr_idx_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        g0_next     = g0_reg;
        g1_next     = g1_reg;
        so_next     = so_reg;
        fg_next     = fg_reg;
        bg_next     = bg_reg;
        bold_next   = bold_reg;
        e0          = '0;
        e1          = '0;
        n           = 2'd0;
        set         = so_reg ? g1_reg : g0_reg;
        gch         = ch_reg;
        acc         = '0;
        nx          = '0;
        tab         = '0;
        hr          = '0;
        hc          = '0;
        e           = '0;
        dn          = '0;
        pc          = '0;
        eff         = '0;
        v           = (cnt == '0) ? '0 : rd_val;

        if (cmd.exec)
        begin
            case (mode_reg)
                PM_GROUND:
                begin
                    if (ch_reg == CH_ESC)
                        mode_next = PM_ESC;
                    else if (ch_reg == CH_LF || ch_reg == CH_VT || ch_reg == CH_FF)
                    begin
                        dn       = calc_down(row_reg, 17'd1, rows);
                        row_next = dn.row;
                        if (dn.scroll)
                        begin
                            e0 = mk(CMD_SCROLL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, dn.lines);
                            n  = 2'd1;
                        end
                    end
                    else if (ch_reg == CH_CR)
                        col_next = 8'd0;
                    else if (ch_reg == CH_TAB)
                    begin
                        tab = {1'b0, col_reg} + 9'(TAB_WIDTH)
                            - 9'({1'b0, col_reg} % 9'(TAB_WIDTH));
                        col_next = (tab >= {1'b0, cols}) ? cols - 8'd1 : tab[7:0];
                    end
                    else if (ch_reg == CH_SO)
                        so_next = 1'b1;
                    else if (ch_reg == CH_SI)
                        so_next = 1'b0;
                    else if (ch_reg == CH_BS)
                    begin
                        if (col_reg != 8'd0)
                        begin
                            col_next = col_reg - 8'd1;
                            e0 = mk(CMD_ERASE, 8'd0, col_reg - 8'd1, row_reg, col_reg,
                                    row_reg + 8'd1, 8'd0);
                            n  = 2'd1;
                        end
                    end
                    else if (ch_reg >= CH_SPACE && ch_reg <= CH_TILDE
                             && (set == CH_0 || set == CH_B))
                    begin
                        if (set == CH_0 && ch_reg == CH_X)
                            gch = CH_BAR;
                        else if (set == CH_0 && ch_reg == CH_Q)
                            gch = CH_DASH;
                        e0 = mk(CMD_DRAW, gch, col_reg, row_reg, 8'd0, 8'd0, 8'd0);
                        n  = 2'd1;
                        if ({1'b0, col_reg} + 9'd1 >= {1'b0, cols})
                        begin
                            col_next = 8'd0;
                            dn       = calc_down(row_reg, 17'd1, rows);
                            row_next = dn.row;
                            if (dn.scroll)
                            begin
                                e1 = mk(CMD_SCROLL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, dn.lines);
                                n  = 2'd2;
                            end
                        end
                        else
                            col_next = col_reg + 8'd1;
                    end
                end
                PM_ESC:
                begin
                    if (ch_reg == CH_LBRK)
                    begin
                        for (int i = 0; i < NUM_PARAMS; i++)
                            params_next[i] = '0;
                        slot_next  = '0;
                        digit_next = 1'b0;
                        mode_next  = PM_CSI;
                    end
                    else if (ch_reg == CH_LPAR)
                        mode_next = PM_SCS0;
                    else if (ch_reg == CH_RPAR)
                        mode_next = PM_SCS1;
                    else
                        mode_next = PM_GROUND;
                end
                PM_CSI:
                begin
                    if (ch_reg == CH_QUEST)
                        mode_next = PM_PRIV;
                    else if (ch_reg >= CH_0 && ch_reg <= CH_9)
                    begin
                        acc = {rd_val, 3'd0} + {3'd0, rd_val, 1'b0}
                            + {12'd0, ch_reg - CH_0};
                        params_next[slot_reg] = (acc > {4'd0, PARAM_MAX}) ? PARAM_MAX
                                                                          : acc[15:0];
                        digit_next = 1'b1;
                    end
                    else if (ch_reg == CH_SEMI)
                    begin
                        slot_next = (slot_reg == SLOT_W'(NUM_PARAMS - 1)) ? '0
                                                                          : slot_reg + 1'b1;
                        params_next[slot_next] = '0;
                        digit_next = 1'b0;
                    end
                    else if (ch_reg == FIN_SGR)
                        sgr_idx_next = '0;
                    else
                    begin
                        case (ch_reg)
                            FIN_UP:
                                row_next = ({8'd0, row_reg} < amt) ? 8'd0
                                         : row_reg - amt[7:0];
                            FIN_BACK:
                                col_next = ({8'd0, col_reg} < amt) ? 8'd0
                                         : col_reg - amt[7:0];
                            FIN_DOWN:
                            begin
                                dn       = calc_down(row_reg, {1'b0, amt}, rows);
                                row_next = dn.row;
                                if (dn.scroll)
                                begin
                                    e0 = mk(CMD_SCROLL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                            dn.lines);
                                    n  = 2'd1;
                                end
                            end
                            FIN_FWD:
                            begin
                                nx = {9'd0, col_reg} + {1'b0, amt};
                                if (nx >= {9'd0, cols})
                                begin
                                    col_next = 8'd0;
                                    dn       = calc_down(row_reg, 17'd1, rows);
                                    row_next = dn.row;
                                    if (dn.scroll)
                                    begin
                                        e0 = mk(CMD_SCROLL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                                dn.lines);
                                        n  = 2'd1;
                                    end
                                end
                                else
                                    col_next = nx[7:0];
                            end
                            FIN_POS:
                            begin
                                pc = params_reg[1 % NUM_PARAMS];
                                hr = amt;
                                hc = (cnt >= CNT_W'(2) && pc != '0) ? pc : 16'd1;
                                row_next = ((hr > {8'd0, rows}) ? rows : hr[7:0]) - 8'd1;
                                col_next = ((hc > {8'd0, cols}) ? cols : hc[7:0]) - 8'd1;
                            end
                            FIN_ED:
                            begin
                                e0 = mk(CMD_ERASE, 8'd0, col_reg, row_reg, cols,
                                        row_reg + 8'd1, 8'd0);
                                n  = 2'd1;
                                if ({1'b0, row_reg} + 9'd1 < {1'b0, rows})
                                begin
                                    e1 = mk(CMD_ERASE, 8'd0, 8'd0, row_reg + 8'd1, cols,
                                            rows, 8'd0);
                                    n  = 2'd2;
                                end
                            end
                            FIN_EL:
                            begin
                                e = {1'b0, col_reg} + 9'd1;
                                if (e > {1'b0, cols})
                                    e = {1'b0, cols};
                                if (p0 == 16'd0)
                                begin
                                    e0 = mk(CMD_ERASE, 8'd0, col_reg, row_reg, cols,
                                            row_reg + 8'd1, 8'd0);
                                    n  = 2'd1;
                                end
                                else if (p0 == 16'd1)
                                begin
                                    e0 = mk(CMD_ERASE, 8'd0, 8'd0, row_reg, e[7:0],
                                            row_reg + 8'd1, 8'd0);
                                    n  = 2'd1;
                                end
                                else if (p0 == 16'd2)
                                begin
                                    e0 = mk(CMD_ERASE, 8'd0, 8'd0, row_reg, cols,
                                            row_reg + 8'd1, 8'd0);
                                    n  = 2'd1;
                                end
                            end
                            default: ;
                        endcase
                        for (int i = 0; i < NUM_PARAMS; i++)
                            params_next[i] = '0;
                        slot_next  = '0;
                        digit_next = 1'b0;
                        mode_next  = PM_GROUND;
                    end
                end
                PM_PRIV:
                    if (ch_reg < CH_0 || ch_reg > CH_9)
                        mode_next = PM_GROUND;
                PM_SCS0:
                begin
                    g0_next   = ch_reg;
                    mode_next = PM_GROUND;
                end
                PM_SCS1:
                begin
                    g1_next   = ch_reg;
                    mode_next = PM_GROUND;
                end
                default: mode_next = PM_GROUND;
            endcase
        end

        // one SGR parameter per cycle
        if (cmd.sgr_step)
        begin
            if (v == 16'd0)
            begin
                fg_next   = FG_RESET;
                bg_next   = 3'd0;
                bold_next = 1'b0;
            end
            else if (v == 16'd1)
                bold_next = 1'b1;
            else if (v == 16'd7)
            begin
                fg_next = bg_reg;
                bg_next = fg_reg;
            end
            else if (v >= 16'd30 && v <= 16'd37)
                fg_next = v[2:0] - 3'd6;
            else if (v >= 16'd40 && v <= 16'd47)
                bg_next = v[2:0];
            sgr_idx_next = sgr_idx_reg + 1'b1;
            if (stat.sgr_last)
            begin
                for (int i = 0; i < NUM_PARAMS; i++)
                    params_next[i] = '0;
                slot_next  = '0;
                digit_next = 1'b0;
                mode_next  = PM_GROUND;
            end
        end

        if (cfg_we)
        begin
            eff = (cfg_data == 8'd0) ? 8'd1 : cfg_data;
            if (cfg_idx == CFG_COLS)
            begin
                cols_next = cfg_data;
                if (col_reg >= eff)
                    col_next = eff - 8'd1;
            end
            else if (cfg_idx == CFG_ROWS)
            begin
                rows_next = cfg_data;
                if (row_reg >= eff)
                    row_next = eff - 8'd1;
            end
        end

        // result words with the current attributes attached
        r0          = e0;
        r0.fg_index = {bold_reg, fg_reg};
        r0.bg_index = bg_reg;
        r0.bold     = bold_reg;
        r0.last     = (n == 2'd1);
        r1          = e1;
        r1.fg_index = {bold_reg, fg_reg};
        r1.bg_index = bg_reg;
        r1.bold     = bold_reg;
        r1.last     = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg    <= COLS_RESET;
            rows_reg    <= ROWS_RESET;
            mode_reg    <= PM_GROUND;
            for (int i = 0; i < NUM_PARAMS; i++)
                params_reg[i] <= '0;
            slot_reg    <= '0;
            digit_reg   <= 1'b0;
            sgr_idx_reg <= '0;
            col_reg     <= 8'd0;
            row_reg     <= 8'd0;
            g0_reg      <= CH_B;
            g1_reg      <= CH_0;
            so_reg      <= 1'b0;
            fg_reg      <= FG_RESET;
            bg_reg      <= 3'd0;
            bold_reg    <= 1'b0;
            two_reg     <= 1'b0;
        end
        else
        begin
            cols_reg    <= cols_next;
            rows_reg    <= rows_next;
            mode_reg    <= mode_next;
            params_reg  <= params_next;
            slot_reg    <= slot_next;
            digit_reg   <= digit_next;
            sgr_idx_reg <= sgr_idx_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            g0_reg      <= g0_next;
            g1_reg      <= g1_next;
            so_reg      <= so_next;
            fg_reg      <= fg_next;
            bg_reg      <= bg_next;
            bold_reg    <= bold_next;
            if (cmd.exec)
                two_reg <= (n == 2'd2);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            ch_reg <= ch;
        if (cmd.exec)
        begin
            res0_reg <= r0;
            res1_reg <= r1;
        end
    end

endmodule

// ===== src/ansi_escape_terminal_engine.sv =====
// Terminal byte parser: one byte in, up to two screen commands out.
// Each byte is loaded, then executed; a CSI 'm' then walks its stored parameters
// (1 to NUM_PARAMS) one per cycle in the attribute walk.
// A new byte is accepted only after the last one's commands have been handed out.
// Reset (rst_n, async low): parser to ground, cursor home, 80x25, G0 'B', G1 '0'.
module ansi_escape_terminal_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    aet_in_if.sink                        stream,
    aet_out_if.source                     cmds,
    input  logic                          cfg_we,
    input  logic [aet_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [7:0]                    cfg_data
);
    import aet_pkg::*;

    ctl_cmd_t  cmd;
    ctl_stat_t stat;
    res_t      res;

    // sequencer: load, execute, SGR walk, then hand out held commands
    aet_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stream.valid),
        .in_ready  (stream.ready),
        .out_valid (cmds.valid),
        .out_ready (cmds.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // parser state, cursor, attributes and the two result words
    aet_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ch       (stream.ch),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .res      (res)
    );

    assign cmds.cmd          = res.cmd;
    assign cmds.glyph        = res.glyph;
    assign cmds.left_col     = res.left_col;
    assign cmds.top_row      = res.top_row;
    assign cmds.right_col    = res.right_col;
    assign cmds.bottom_row   = res.bottom_row;
    assign cmds.scroll_lines = res.scroll_lines;
    assign cmds.fg_index     = res.fg_index;
    assign cmds.bg_index     = res.bg_index;
    assign cmds.bold         = res.bold;
    assign cmds.last         = res.last;

endmodule

// ===== src/aet_checker.sv =====
module aet_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] out_cmd,
    input logic       out_last
);
    import aet_pkg::*;

    // a held word stays until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped");

    // one byte at a time: no accept while commands are pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while output pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready && !out_valid)
        else $error("accept not followed by execute");

    // second command of a byte follows the first at once
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=> out_valid)
        else $error("missing second command");

    a_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_cmd == CMD_DRAW || out_cmd == CMD_ERASE
                       || out_cmd == CMD_SCROLL))
        else $error("bad command code");

endmodule

bind ansi_escape_terminal_engine aet_checker u_aet_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (stream.valid),
    .in_ready  (stream.ready),
    .out_valid (cmds.valid),
    .out_ready (cmds.ready),
    .out_cmd   (cmds.cmd),
    .out_last  (cmds.last)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import aet_pkg::*;

    // clock, reset, ports
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [7:0] cfg_data = '0;

    aet_in_if  byte_if ();
    aet_out_if cmd_if ();

    initial
    begin
        byte_if.valid = 1'b0;
        byte_if.ch    = 8'h00;
        cmd_if.ready  = 1'b0;
    end

    always #10 clk = ~clk;

    ansi_escape_terminal_engine uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .stream   (byte_if.sink),
        .cmds     (cmd_if.source),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    // shadow terminal state, tracked per accepted byte
    logic [2:0]  mode;
    int unsigned params [NUM_PARAMS];
    int unsigned slot;
    bit          digit_seen;
    int unsigned cur_col, cur_row;
    logic [7:0]  g0_set, g1_set;
    bit          shift_out;
    logic [2:0]  fg, bg;
    bit          bold_on;
    int unsigned cols_reg, rows_reg;

    res_t new_cmds [$];        // commands caused by the byte being modeled
    res_t screen_cmds_due [$]; // commands still owed by the block

    int errors = 0;
    int bytes_sent = 0;
    int idle_pct = 32;
    int stall_cnt = 0;

    task automatic report(input string what);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function automatic int unsigned ncols();
        return (cols_reg != 0) ? cols_reg : 1;
    endfunction

    function automatic int unsigned nrows();
        return (rows_reg != 0) ? rows_reg : 1;
    endfunction

    function automatic void model_reset();
        cols_reg = COLS_RESET;
        rows_reg = ROWS_RESET;
        mode = PM_GROUND;
        foreach (params[i]) params[i] = 0;
        slot = 0;
        digit_seen = 0;
        cur_col = 0;
        cur_row = 0;
        g0_set = CH_B;
        g1_set = CH_0;
        shift_out = 0;
        fg = FG_RESET;
        bg = 3'd0;
        bold_on = 0;
    endfunction

    function automatic void clear_csi();
        foreach (params[i]) params[i] = 0;
        slot = 0;
        digit_seen = 0;
    endfunction

    // at most two commands per byte; attributes ride on every one
    function automatic void add_cmd(input logic [1:0] cmd, input int unsigned g,
                                    input int unsigned l, input int unsigned t,
                                    input int unsigned r, input int unsigned b,
                                    input int unsigned s);
        res_t c;
        if (new_cmds.size() >= 2) return;
        c.cmd = cmd;
        c.glyph = g[7:0];
        c.left_col = l[7:0];
        c.top_row = t[7:0];
        c.right_col = r[7:0];
        c.bottom_row = b[7:0];
        c.scroll_lines = s[7:0];
        c.fg_index = {bold_on, fg};
        c.bg_index = bg;
        c.bold = bold_on;
        c.last = 1'b0;
        new_cmds.push_back(c);
    endfunction

    function automatic void go_down(input int unsigned add);
        int unsigned ny;
        int unsigned s;
        ny = cur_row + add;
        if (ny >= nrows())
        begin
            s = ny - nrows() + 1;
            if (s > nrows()) s = nrows();
            add_cmd(CMD_SCROLL, 0, 0, 0, 0, 0, s);
            ny = nrows() - 1;
        end
        cur_row = ny;
    endfunction

    function automatic void go_right(input int unsigned add);
        if (cur_col + add >= ncols())
        begin
            cur_col = 0;
            go_down(1);
        end
        else
            cur_col = cur_col + add;
    endfunction

    function automatic void put_char(input logic [7:0] c);
        logic [7:0] set;
        logic [7:0] g;
        set = shift_out ? g1_set : g0_set;
        g = c;
        if (c < CH_SPACE || c > CH_TILDE) return;
        if (set == CH_0)
        begin
            if (c == CH_X) g = CH_BAR;
            else if (c == CH_Q) g = CH_DASH;
        end
        else if (set != CH_B)
            return;
        add_cmd(CMD_DRAW, g, cur_col, cur_row, 0, 0, 0);
        go_right(1);
    endfunction

    function automatic void run_final(input logic [7:0] fin);
        int unsigned cnt, p0, amt, r, c, e, v;
        logic [2:0] t;
        cnt = slot + (digit_seen ? 1 : 0);
        p0 = (cnt != 0) ? params[0] : 0;
        amt = (p0 != 0) ? p0 : 1;
        case (fin)
            FIN_UP:   cur_row = (amt > cur_row) ? 0 : cur_row - amt;
            FIN_DOWN: go_down(amt);
            FIN_FWD:  go_right(amt);
            FIN_BACK: cur_col = (amt > cur_col) ? 0 : cur_col - amt;
            FIN_POS:
            begin
                r = amt;
                c = (cnt >= 2 && params[1 % NUM_PARAMS] != 0) ? params[1 % NUM_PARAMS] : 1;
                cur_row = ((r > nrows()) ? nrows() : r) - 1;
                cur_col = ((c > ncols()) ? ncols() : c) - 1;
            end
            FIN_ED:
            begin
                add_cmd(CMD_ERASE, 0, cur_col, cur_row, ncols(), cur_row + 1, 0);
                if (cur_row + 1 < nrows())
                    add_cmd(CMD_ERASE, 0, 0, cur_row + 1, ncols(), nrows(), 0);
            end
            FIN_EL:
            begin
                if (p0 == 0)
                    add_cmd(CMD_ERASE, 0, cur_col, cur_row, ncols(), cur_row + 1, 0);
                else if (p0 == 1)
                begin
                    e = cur_col + 1;
                    if (e > ncols()) e = ncols();
                    add_cmd(CMD_ERASE, 0, 0, cur_row, e, cur_row + 1, 0);
                end
                else if (p0 == 2)
                    add_cmd(CMD_ERASE, 0, 0, cur_row, ncols(), cur_row + 1, 0);
            end
            FIN_SGR:
            begin
                if (cnt == 0)
                begin
                    params[0] = 0;
                    cnt = 1;
                end
                if (cnt > NUM_PARAMS) cnt = NUM_PARAMS;
                for (int i = 0; i < cnt; i++)
                begin
                    v = params[i];
                    if (v == 0)
                    begin
                        fg = FG_RESET;
                        bg = 3'd0;
                        bold_on = 0;
                    end
                    else if (v == 1) bold_on = 1;
                    else if (v == 7)
                    begin
                        t = fg;
                        fg = bg;
                        bg = t;
                    end
                    else if (v >= 30 && v <= 37) fg = 3'(v - 30);
                    else if (v >= 40 && v <= 47) bg = 3'(v - 40);
                end
            end
            default: ;
        endcase
    endfunction

    // advance the shadow state by one byte; fills new_cmds
    function automatic void model_byte(input logic [7:0] c);
        int unsigned s, v;
        res_t tail;
        new_cmds.delete();
        case (mode)
            PM_GROUND:
            begin
                if (c == CH_ESC) mode = PM_ESC;
                else if (c == CH_LF || c == CH_VT || c == CH_FF) go_down(1);
                else if (c == CH_CR) cur_col = 0;
                else if (c == CH_TAB)
                begin
                    v = cur_col + (TAB_WIDTH - cur_col % TAB_WIDTH);
                    cur_col = (v >= ncols()) ? ncols() - 1 : v;
                end
                else if (c == CH_SO) shift_out = 1;
                else if (c == CH_SI) shift_out = 0;
                else if (c == CH_BS)
                begin
                    if (cur_col != 0)
                    begin
                        cur_col--;
                        add_cmd(CMD_ERASE, 0, cur_col, cur_row, cur_col + 1, cur_row + 1, 0);
                    end
                end
                else put_char(c);
            end
            PM_ESC:
            begin
                if (c == CH_LBRK)
                begin
                    clear_csi();
                    mode = PM_CSI;
                end
                else if (c == CH_LPAR) mode = PM_SCS0;
                else if (c == CH_RPAR) mode = PM_SCS1;
                else mode = PM_GROUND;
            end
            PM_CSI:
            begin
                s = slot % NUM_PARAMS;
                if (c == CH_QUEST) mode = PM_PRIV;
                else if (c >= CH_0 && c <= CH_9)
                begin
                    v = params[s] * 10 + (c - CH_0);
                    params[s] = (v > PARAM_MAX) ? PARAM_MAX : v;
                    digit_seen = 1;
                end
                else if (c == CH_SEMI)
                begin
                    slot = (s + 1) % NUM_PARAMS;
                    params[slot] = 0;
                    digit_seen = 0;
                end
                else
                begin
                    run_final(c);
                    clear_csi();
                    mode = PM_GROUND;
                end
            end
            PM_PRIV: if (c < CH_0 || c > CH_9) mode = PM_GROUND;
            PM_SCS0:
            begin
                g0_set = c;
                mode = PM_GROUND;
            end
            PM_SCS1:
            begin
                g1_set = c;
                mode = PM_GROUND;
            end
            default: mode = PM_GROUND;
        endcase
        if (new_cmds.size() > 0)
        begin
            tail = new_cmds.pop_back();
            tail.last = 1'b1;
            new_cmds.push_back(tail);
        end
    endfunction

    // send one byte; idles at random first, models it once accepted
    task automatic send_byte(input logic [7:0] c);
        while ($urandom_range(99) < idle_pct)
        begin
            byte_if.valid <= 1'b0;
            @(posedge clk);
        end
        byte_if.valid <= 1'b1;
        byte_if.ch <= c;
        do @(posedge clk); while (!byte_if.ready);
        bytes_sent++;
        model_byte(c);
        foreach (new_cmds[i]) screen_cmds_due.push_back(new_cmds[i]);
    endtask

    // register write only once the block has drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge clk);
        byte_if.valid <= 1'b0;
        wait (screen_cmds_due.size() == 0);
        repeat (12) @(posedge clk);  // CSI m walk can still be running
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_COLS) cols_reg = val;
        else if (idx == CFG_ROWS) rows_reg = val;
        else return;
        if (cur_col >= ncols()) cur_col = ncols() - 1;
        if (cur_row >= nrows()) cur_row = nrows() - 1;
    endtask

    task automatic send_num(input int unsigned v);
        logic [7:0] digs [$];
        do
        begin
            digs.push_front(8'(CH_0 + v % 10));
            v = v / 10;
        end
        while (v != 0);
        foreach (digs[i]) send_byte(digs[i]);
    endtask

    function automatic int unsigned pick_param();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 30) return $urandom_range(9);
        if (k < 45) return 30 + $urandom_range(7);
        if (k < 60) return 40 + $urandom_range(7);
        if (k < 70) return $urandom_range(300);
        if (k < 75) return 60000 + $urandom_range(9999999);  // saturates
        return $urandom_range(60);
    endfunction

    task automatic send_csi();
        logic [7:0] finals [9] = '{FIN_UP, FIN_DOWN, FIN_FWD, FIN_BACK, FIN_POS,
                                   FIN_ED, FIN_EL, FIN_SGR, 8'h00};
        int np;
        logic [7:0] fin;
        send_byte(CH_ESC);
        send_byte(CH_LBRK);
        np = ($urandom_range(9) == 0) ? 6 + $urandom_range(2) : $urandom_range(3);
        for (int i = 0; i < np; i++)
        begin
            if (i != 0) send_byte(CH_SEMI);
            if ($urandom_range(9) != 0) send_num(pick_param());
        end
        fin = finals[$urandom_range(8)];
        if (fin == 8'h00) fin = 8'($urandom_range(8'h40, 8'h7E));
        send_byte(fin);
    endtask

    // one well-formed sequence or a bit of noise
    task automatic send_group();
        logic [7:0] ctls [8] = '{CH_BS, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_SO, CH_SI};
        int k;
        k = $urandom_range(99);
        if (k < 30)
        begin
            repeat (1 + $urandom_range(7))
                send_byte(($urandom_range(3) == 0) ? (($urandom_range(1) != 0) ? CH_X : CH_Q)
                                                   : 8'($urandom_range(CH_SPACE, CH_TILDE)));
        end
        else if (k < 55)
            send_csi();
        else if (k < 62)
        begin
            send_byte(CH_ESC);
            send_byte(($urandom_range(1) != 0) ? CH_LPAR : CH_RPAR);
            k = $urandom_range(3);
            send_byte((k == 0) ? 8'($urandom_range(255)) : (k == 1) ? CH_B : CH_0);
        end
        else if (k < 77)
            send_byte(ctls[$urandom_range(7)]);
        else if (k < 82)
        begin
            send_byte(CH_ESC);
            send_byte(CH_LBRK);
            send_byte(CH_QUEST);
            if ($urandom_range(1) != 0) send_num($urandom_range(2000));
            send_byte(8'($urandom_range(255)));
        end
        else
            send_byte(8'($urandom_range(255)));
    endtask

    // output side: check each accepted word, then pick the next ready
    always @(posedge clk)
    begin
        res_t got, want;
        if (rst_n && cmd_if.valid && cmd_if.ready)
        begin
            got = '{cmd_if.cmd, cmd_if.glyph, cmd_if.left_col, cmd_if.top_row,
                    cmd_if.right_col, cmd_if.bottom_row, cmd_if.scroll_lines,
                    cmd_if.fg_index, cmd_if.bg_index, cmd_if.bold, cmd_if.last};
            if (screen_cmds_due.size() == 0)
                report($sformatf("unexpected command %h", got));
            else
            begin
                want = screen_cmds_due.pop_front();
                if (got.cmd != want.cmd) report($sformatf("cmd %0d want %0d", got.cmd, want.cmd));
                if (got.glyph != want.glyph)
                    report($sformatf("glyph %h want %h", got.glyph, want.glyph));
                if (got.left_col != want.left_col)
                    report($sformatf("left_col %0d want %0d", got.left_col, want.left_col));
                if (got.top_row != want.top_row)
                    report($sformatf("top_row %0d want %0d", got.top_row, want.top_row));
                if (got.right_col != want.right_col)
                    report($sformatf("right_col %0d want %0d", got.right_col, want.right_col));
                if (got.bottom_row != want.bottom_row)
                    report($sformatf("bottom_row %0d want %0d", got.bottom_row, want.bottom_row));
                if (got.scroll_lines != want.scroll_lines)
                    report($sformatf("scroll_lines %0d want %0d", got.scroll_lines,
                                     want.scroll_lines));
                if (got.fg_index != want.fg_index)
                    report($sformatf("fg_index %0d want %0d", got.fg_index, want.fg_index));
                if (got.bg_index != want.bg_index)
                    report($sformatf("bg_index %0d want %0d", got.bg_index, want.bg_index));
                if (got.bold != want.bold) report($sformatf("bold %0d want %0d", got.bold, want.bold));
                if (got.last != want.last) report($sformatf("last %0d want %0d", got.last, want.last));
            end
        end
        cmd_if.ready <= ($urandom_range(99) >= idle_pct);
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_if.valid && byte_if.ready) || (cmd_if.valid && cmd_if.ready))
                stall_cnt <= 0;
            else if (stall_cnt >= 5000)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
                stall_cnt <= stall_cnt + 1;
        end
    end

    typedef struct {
        logic [7:0] ch;
        bit         typed;
        res_t       want;
    } dir_row_t;

    initial
    begin
        dir_row_t dir_tab [$];
        logic [7:0] plain [] = '{CH_BS, CH_TAB, CH_CR, CH_LF, CH_VT, CH_FF, 8'h07, 8'hFF, 8'h00,
                                 CH_ESC, CH_LPAR, CH_0, CH_X, CH_Q, CH_ESC, CH_RPAR, 8'h5A,
                                 CH_SO, 8'h61, CH_SI, CH_ESC, 8'h63};
        int target;
        logic [7:0] cfg_cols [6] = '{8'd10, 8'd1, 8'd255, 8'd0, 8'd3, 8'd80};
        logic [7:0] cfg_rows [6] = '{8'd4, 8'd1, 8'd255, 8'd0, 8'd2, 8'd25};

        model_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: fresh-reset draws are typed in, the rest go through the model
        dir_tab.push_back('{8'h41, 1'b1, '{CMD_DRAW, 8'h41, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                           4'd7, 3'd0, 1'b0, 1'b1}});
        dir_tab.push_back('{CH_TILDE, 1'b1, '{CMD_DRAW, CH_TILDE, 8'd1, 8'd0, 8'd0, 8'd0,
                                              8'd0, 4'd7, 3'd0, 1'b0, 1'b1}});
        foreach (plain[i]) dir_tab.push_back('{plain[i], 1'b0, '0});
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].typed)
            begin
                while ($urandom_range(99) < idle_pct)
                begin
                    byte_if.valid <= 1'b0;
                    @(posedge clk);
                end
                byte_if.valid <= 1'b1;
                byte_if.ch <= dir_tab[i].ch;
                do @(posedge clk); while (!byte_if.ready);
                bytes_sent++;
                model_byte(dir_tab[i].ch);
                screen_cmds_due.push_back(dir_tab[i].want);
            end
            else
                send_byte(dir_tab[i].ch);
        end

        // random phases across screen sizes, including the zero-acts-as-one
        // and largest sizes; phase 2 runs with no idling on either side
        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph < 6)
            begin
                write_reg(CFG_COLS, cfg_cols[ph]);
                write_reg(CFG_ROWS, cfg_rows[ph]);
            end
            else
                write_reg(2'd3, 8'hA5);  // unused index, no effect
            idle_pct = (ph == 2) ? 0 : 32;
            target = bytes_sent + 260;
            while (bytes_sent < target) send_group();
        end

        @(posedge clk);
        byte_if.valid <= 1'b0;
        wait (screen_cmds_due.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
src/aet_pkg.sv
src/aet_if.sv
src/aet_ctrl.sv
src/aet_dp.sv
src/ansi_escape_terminal_engine.sv
src/aet_checker.sv
sim/tb_top.sv
